>>> rtl/sync_length_frame_extractor_defines.svh
// assertion macros shared by the deframer modules
`ifndef SYNC_LENGTH_FRAME_EXTRACTOR_DEFINES_SVH
`define SYNC_LENGTH_FRAME_EXTRACTOR_DEFINES_SVH

// condition must hold in the same cycle
`define SLFE_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition must hold in the following cycle
`define SLFE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/slfe_pkg.sv
// shared types and constants of the sync/length deframer
package slfe_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned CIDX_W  = 2;
    localparam int unsigned REM_W   = 9;

    typedef logic [BYTE_W-1:0] t_byte;
    typedef logic [CIDX_W-1:0] t_cfg_idx;
    typedef logic [REM_W-1:0]  t_rem;

    // register indexes
    localparam t_cfg_idx CFG_SYNC_FIRST  = t_cfg_idx'(0);
    localparam t_cfg_idx CFG_SYNC_SECOND = t_cfg_idx'(1);

    // register reset values
    localparam t_byte SYNC_FIRST_RST  = 8'h49;
    localparam t_byte SYNC_SECOND_RST = 8'h43;

    // one queued piece of work: a sync pair or one frame byte
    typedef struct packed {
        logic  pair;
        logic  last;
        t_byte lead;
        t_byte data;
    } t_entry;

    // front to queue write side
    typedef struct packed {
        logic   push;
        t_entry entry;
    } t_push;

endpackage

>>> rtl/slfe_if.sv
// handshake channels of the deframer: received bytes, frame bytes, register writes
interface slfe_rx_if import slfe_pkg::*; ();
    logic  valid;
    logic  ready;
    t_byte rx_byte;
    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface slfe_frame_if import slfe_pkg::*; ();
    logic  valid;
    logic  ready;
    t_byte frame_byte;
    logic  frame_first;
    logic  frame_last;
    logic  run_last;
    modport source (output valid, output frame_byte, output frame_first,
                    output frame_last, output run_last, input ready);
    modport sink   (input valid, input frame_byte, input frame_first,
                    input frame_last, input run_last, output ready);
endinterface

interface slfe_cfg_if import slfe_pkg::*; ();
    logic     valid;
    logic     ready;
    t_cfg_idx index;
    t_byte    data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/slfe_front.sv
// front end: sync hunt, length capture and frame byte classification
`include "sync_length_frame_extractor_defines.svh"

module slfe_front import slfe_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    slfe_rx_if.sink       i_rx,
    slfe_cfg_if.sink      i_cfg,
    input  logic          i_full,
    output t_push         o_push
);

    typedef enum logic [2:0] {
        ST_HUNT   = 3'd0,
        ST_SECOND = 3'd1,
        ST_LEN    = 3'd2,
        ST_FIRST  = 3'd3,
        ST_MORE   = 3'd4
    } t_state;

    t_state r_state, n_state;
    t_rem   r_rem, n_rem;
    t_byte  r_sync_first, r_sync_second;
    logic   w_accept;
    t_rem   w_dec;
    t_push  w_push;

    assign i_cfg.ready = 1'b1;
    assign i_rx.ready  = !i_full;
    assign w_accept    = i_rx.valid && !i_full;
    assign w_dec       = (r_rem != '0) ? r_rem - t_rem'(1) : '0;

    // register writes, unknown indexes dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_first  <= SYNC_FIRST_RST;
            r_sync_second <= SYNC_SECOND_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_SYNC_FIRST:  r_sync_first  <= i_cfg.data;
                CFG_SYNC_SECOND: r_sync_second <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // classify the incoming byte
    always_comb begin
        n_state            = r_state;
        n_rem              = r_rem;
        w_push.push        = 1'b0;
        w_push.entry.pair  = 1'b0;
        w_push.entry.last  = 1'b0;
        w_push.entry.lead  = r_sync_first;
        w_push.entry.data  = i_rx.rx_byte;
        if (w_accept) begin
            unique case (r_state)
                ST_SECOND: begin
                    if (i_rx.rx_byte == r_sync_second) begin
                        w_push.push       = 1'b1;
                        w_push.entry.pair = 1'b1;
                        n_state           = ST_LEN;
                        n_rem             = '0;
                    end else begin
                        n_state = ST_HUNT;
                    end
                end
                ST_LEN: begin
                    w_push.push = 1'b1;
                    n_rem       = t_rem'(i_rx.rx_byte) + t_rem'(1);
                    n_state     = ST_FIRST;
                end
                ST_FIRST: begin
                    w_push.push = 1'b1;
                    n_rem       = w_dec;
                    n_state     = ST_MORE;
                end
                ST_MORE: begin
                    w_push.push       = 1'b1;
                    w_push.entry.last = (w_dec == '0);
                    n_rem             = w_dec;
                    if (w_dec == '0) begin
                        n_state = ST_HUNT;
                    end
                end
                default: begin
                    if (i_rx.rx_byte == r_sync_first) begin
                        n_state = ST_SECOND;
                        n_rem   = '0;
                    end else begin
                        n_state = ST_HUNT;
                    end
                end
            endcase
        end
    end

    // state and byte count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_HUNT;
            r_rem   <= '0;
        end else begin
            r_state <= n_state;
            r_rem   <= n_rem;
        end
    end

    assign o_push = w_push;

    `SLFE_ASSERT_NOW(a_first_owes, i_clk, i_rst_n, r_state == ST_FIRST, r_rem != '0,
        "first payload byte expected with nothing owed")
    `SLFE_ASSERT_NOW(a_last_in_more, i_clk, i_rst_n, w_push.push && w_push.entry.last,
        r_state == ST_MORE, "frame end raised outside payload")
    `SLFE_ASSERT_NOW(a_no_push_full, i_clk, i_rst_n, i_full, !w_push.push,
        "item queued while queue full")

endmodule

>>> rtl/slfe_queue.sv
// small fifo between front and back ends
`include "sync_length_frame_extractor_defines.svh"

module slfe_queue import slfe_pkg::*; #(
    parameter int unsigned DEPTH = 4
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_push  i_push,
    input  logic   i_pop,
    output logic   o_full,
    output logic   o_empty,
    output t_entry o_head
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    t_entry           r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             w_wr, w_rd;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign w_wr    = i_push.push && !o_full;
    assign w_rd    = i_pop && !o_empty;
    assign o_head  = r_mem[r_rd];

    // storage
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr] <= i_push.entry;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) begin
                r_wr <= (r_wr == LAST_PTR) ? '0 : r_wr + PTR_W'(1);
            end
            if (w_rd) begin
                r_rd <= (r_rd == LAST_PTR) ? '0 : r_rd + PTR_W'(1);
            end
            case ({w_wr, w_rd})
                2'b10:   r_cnt <= r_cnt + CNT_W'(1);
                2'b01:   r_cnt <= r_cnt - CNT_W'(1);
                default: ;
            endcase
        end
    end

    `SLFE_ASSERT_NOW(a_cnt_range, i_clk, i_rst_n, 1'b1, r_cnt <= CNT_W'(DEPTH),
        "fill count beyond depth")
    `SLFE_ASSERT_NOW(a_empty_ptrs, i_clk, i_rst_n, o_empty, r_wr == r_rd,
        "pointers apart while empty")
    `SLFE_ASSERT_NEXT(a_cnt_step, i_clk, i_rst_n, w_wr && !w_rd && !o_full, !o_empty,
        "queue empty after a write")

endmodule

>>> rtl/slfe_back.sv
// back end: expands sync pairs and drives the frame output register
`include "sync_length_frame_extractor_defines.svh"

module slfe_back import slfe_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_empty,
    input  t_entry       i_head,
    output logic         o_pop,
    slfe_frame_if.source o_frame
);

    logic  r_valid, r_half;
    t_byte r_byte;
    logic  r_first, r_last, r_run_last;
    logic  w_load, w_lead;

    // output register free, head can go out
    assign w_load = (!r_valid || o_frame.ready) && !i_empty;
    // first half of a sync pair stays in the queue
    assign w_lead = i_head.pair && !r_half;
    assign o_pop  = w_load && !w_lead;

    // control flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_half  <= 1'b0;
        end else if (!r_valid || o_frame.ready) begin
            r_valid <= !i_empty;
            if (!i_empty) begin
                r_half <= w_lead;
            end
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_byte     <= w_lead ? i_head.lead : i_head.data;
            r_first    <= w_lead;
            r_last     <= !w_lead && i_head.last;
            r_run_last <= !w_lead;
        end
    end

    assign o_frame.valid       = r_valid;
    assign o_frame.frame_byte  = r_byte;
    assign o_frame.frame_first = r_first;
    assign o_frame.frame_last  = r_last;
    assign o_frame.run_last    = r_run_last;

    `SLFE_ASSERT_NOW(a_half_held, i_clk, i_rst_n, r_half,
        r_valid && r_first && !r_run_last, "pair half without leading sync item")
    `SLFE_ASSERT_NOW(a_first_not_last, i_clk, i_rst_n, r_valid && r_first,
        !r_last, "frame start marked as frame end")
    `SLFE_ASSERT_NOW(a_pop_nonempty, i_clk, i_rst_n, o_pop, !i_empty,
        "pop from empty queue")

endmodule

>>> rtl/sync_length_frame_extractor.sv
// top level of the sync/length prefixed frame extractor
//
//  port     dir  role              payload
//  i_rx     in   received bytes    rx_byte
//  o_frame  out  frame bytes       frame_byte, frame_first, frame_last, run_last
//  i_cfg    in   register writes   index (0 sync_first, 1 sync_second), data
//
// one received byte accepted per cycle while the queue has room
// a matched sync pair leaves as two items from the output stage
// queue written at the accept edge, output register then loaded from the queue head
// synchronous active-low reset, no clearing pass; output stalls back up through the queue
module sync_length_frame_extractor import slfe_pkg::*; #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    slfe_rx_if.sink      i_rx,
    slfe_frame_if.source o_frame,
    slfe_cfg_if.sink     i_cfg
);

    t_push  w_push;
    t_entry w_head;
    logic   w_full, w_empty, w_pop;

    // byte classification
    slfe_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (i_rx),
        .i_cfg   (i_cfg),
        .i_full  (w_full),
        .o_push  (w_push)
    );

    // decoupling queue
    slfe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_head  (w_head)
    );

    // result emission
    slfe_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (w_empty),
        .i_head  (w_head),
        .o_pop   (w_pop),
        .o_frame (o_frame)
    );

endmodule

>>> test/sync_length_frame_extractor_tb.sv
// self-checking testbench of the sync/length frame extractor against a cycle-free predictor
module sync_length_frame_extractor_tb import slfe_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam t_byte    SYNC_FIRST_ALT = 8'h50;
    localparam t_cfg_idx CFG_SPARE_LO   = t_cfg_idx'(2);
    localparam t_cfg_idx CFG_SPARE_HI   = t_cfg_idx'(3);
    localparam int       SETTLE_CYCLES  = 8;
    localparam int       HOLD_AT        = 480;
    localparam int       HOLD_LEN       = 300;
    localparam int       STALL_LIMIT    = 5000;

    // deframer phases as the predictor tracks them
    typedef enum logic [2:0] {
        ST_HUNT  = 3'd0,
        ST_SYNC2 = 3'd1,
        ST_LEN   = 3'd2,
        ST_PAY1  = 3'd3,
        ST_PAYN  = 3'd4
    } t_hunt;

    typedef enum logic [1:0] {
        IDLE_NONE,
        IDLE_RANDOM,
        IDLE_PERIODIC
    } t_idle;

    typedef struct packed {
        t_byte data;
        logic  first;
        logic  last;
        logic  run_end;
    } t_frame_out;

    logic i_clk = 1'b0;
    logic i_rst_n;

    slfe_rx_if    rx_if ();
    slfe_frame_if frame_if ();
    slfe_cfg_if   cfg_if ();

    sync_length_frame_extractor dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_if),
        .o_frame (frame_if),
        .i_cfg   (cfg_if)
    );

    // byte stream waiting to be offered and frame items still owed
    t_byte      rx_backlog[$];
    t_frame_out expected_frame_bytes[$];

    // predictor state and register copies
    t_hunt st = ST_HUNT;
    t_rem  owed = '0;
    t_byte pred_first = SYNC_FIRST_RST;
    t_byte pred_second = SYNC_SECOND_RST;

    // register values the stimulus builds frames from
    t_byte cur_first = SYNC_FIRST_RST;
    t_byte cur_second = SYNC_SECOND_RST;

    int    bytes_queued = 0;
    int    rx_taken = 0;
    int    errors = 0;
    int    stall_cycles = 0;
    int    burst_left = 0;
    int    gap_left = 0;
    int    hold_left = 0;
    bit    hold_done = 1'b0;
    int    sink_cycle = 0;
    bit    source_gaps = 1'b0;
    t_idle sink_mode = IDLE_NONE;

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic void predict_out(t_byte b, logic first, logic last, logic run_end);
        t_frame_out item;
        item.data    = b;
        item.first   = first;
        item.last    = last;
        item.run_end = run_end;
        expected_frame_bytes.push_back(item);
    endfunction

    // one received byte through the predictor
    function automatic void deframe_predict(t_byte b);
        logic done;
        case (st)
            ST_SYNC2: begin
                if (b == pred_second) begin
                    predict_out(pred_first, 1'b1, 1'b0, 1'b0);
                    predict_out(pred_second, 1'b0, 1'b0, 1'b1);
                    st   = ST_LEN;
                    owed = '0;
                end else begin
                    // dropped, not tried as a new first sync byte
                    st = ST_HUNT;
                end
            end
            ST_LEN: begin
                owed = t_rem'(b) + t_rem'(1);
                st   = ST_PAY1;
                predict_out(b, 1'b0, 1'b0, 1'b1);
            end
            ST_PAY1: begin
                if (owed != '0) owed = owed - t_rem'(1);
                st = ST_PAYN;
                predict_out(b, 1'b0, 1'b0, 1'b1);
            end
            ST_PAYN: begin
                if (owed != '0) owed = owed - t_rem'(1);
                done = (owed == '0);
                if (done) st = ST_HUNT;
                predict_out(b, 1'b0, done, 1'b1);
            end
            default: begin
                if (b == pred_first) begin
                    st   = ST_SYNC2;
                    owed = '0;
                end else begin
                    st = ST_HUNT;
                end
            end
        endcase
    endfunction

    function automatic void queue_byte(t_byte b);
        rx_backlog.push_back(b);
        bytes_queued++;
    endfunction

    function automatic t_byte rand_byte();
        return t_byte'($urandom_range(0, 255));
    endfunction

    // sync pair, length byte, then body random bytes
    function automatic void push_frame(int len, int body);
        queue_byte(cur_first);
        queue_byte(cur_second);
        queue_byte(t_byte'(len));
        repeat (body) queue_byte(rand_byte());
    endfunction

    // mostly well-formed frames, some noise and broken sequences
    function automatic void push_traffic(int n);
        int    goal;
        int    pick;
        int    len;
        goal = bytes_queued + n;
        while (bytes_queued < goal) begin
            pick = $urandom_range(0, 9);
            if (pick <= 5) begin
                len = ($urandom_range(0, 15) == 0) ? $urandom_range(7, 40)
                                                   : $urandom_range(0, 6);
                push_frame(len, ((len < 1) ? 1 : len) + 1);
            end else if (pick == 6) begin
                repeat ($urandom_range(1, 4)) queue_byte(rand_byte());
            end else if (pick == 7) begin
                // second sync byte wrong
                queue_byte(cur_first);
                queue_byte(cur_second ^ t_byte'($urandom_range(1, 255)));
            end else if (pick == 8) begin
                // frame cut short, later bytes run into it
                len = $urandom_range(3, 10);
                push_frame(len, $urandom_range(0, len));
            end else begin
                queue_byte(cur_first);
                queue_byte(cur_first);
                queue_byte(cur_second);
            end
        end
    endfunction

    task automatic write_reg(input t_cfg_idx idx, input t_byte val);
        @(posedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        do @(posedge i_clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        case (idx)
            CFG_SYNC_FIRST:  cur_first = val;
            CFG_SYNC_SECOND: cur_second = val;
            default: ;
        endcase
    endtask

    // wait until every queued byte is taken and every frame item has come out
    task automatic settle();
        do @(posedge i_clk);
        while (rx_taken != bytes_queued || expected_frame_bytes.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // byte driver, bursts with gaps between them while source gaps are enabled
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rx_if.valid <= 1'b0;
            burst_left  <= 0;
            gap_left    <= 0;
        end else if (!rx_if.valid || rx_if.ready) begin
            if (gap_left != 0) begin
                gap_left    <= gap_left - 1;
                rx_if.valid <= 1'b0;
            end else if (rx_backlog.size() != 0) begin
                rx_if.valid   <= 1'b1;
                rx_if.rx_byte <= rx_backlog.pop_front();
                if (burst_left > 1) begin
                    burst_left <= burst_left - 1;
                end else begin
                    burst_left <= $urandom_range(1, 16);
                    gap_left   <= source_gaps ? $urandom_range(0, 6) : 0;
                end
            end else begin
                rx_if.valid <= 1'b0;
            end
        end
    end

    // frame receiver stall pattern, with one long hold-off
    always @(posedge i_clk) begin
        sink_cycle <= sink_cycle + 1;
        if (!i_rst_n) begin
            frame_if.ready <= 1'b0;
        end else if (hold_left != 0) begin
            frame_if.ready <= 1'b0;
            hold_left      <= hold_left - 1;
        end else if (!hold_done && rx_taken >= HOLD_AT) begin
            frame_if.ready <= 1'b0;
            hold_left      <= HOLD_LEN;
            hold_done      <= 1'b1;
        end else begin
            case (sink_mode)
                IDLE_RANDOM:   frame_if.ready <= ($urandom_range(0, 2) != 0);
                IDLE_PERIODIC: frame_if.ready <= ((sink_cycle % 9) < 5);
                default:       frame_if.ready <= 1'b1;
            endcase
        end
    end

    // output check first, then register and byte updates of the predictor
    always @(posedge i_clk) begin
        t_frame_out got;
        t_frame_out want;
        if (i_rst_n) begin
            if (frame_if.valid && frame_if.ready) begin
                got.data    = frame_if.frame_byte;
                got.first   = frame_if.frame_first;
                got.last    = frame_if.frame_last;
                got.run_end = frame_if.run_last;
                if (expected_frame_bytes.size() == 0) begin
                    $display("%0t: unexpected frame item, expected none, got %02h %b%b%b",
                             $time, got.data, got.first, got.last, got.run_end);
                    errors++;
                end else begin
                    want = expected_frame_bytes.pop_front();
                    if (got.data != want.data || got.first != want.first ||
                        got.last != want.last || got.run_end != want.run_end) begin
                        $display("%0t: frame item mismatch, expected byte %02h first %b",
                                 $time, want.data, want.first,
                                 " last %b run %b, got byte %02h first %b last %b run %b",
                                 want.last, want.run_end, got.data, got.first,
                                 got.last, got.run_end);
                        errors++;
                    end
                end
            end
            if (cfg_if.valid && cfg_if.ready) begin
                case (cfg_if.index)
                    CFG_SYNC_FIRST:  pred_first = cfg_if.data;
                    CFG_SYNC_SECOND: pred_second = cfg_if.data;
                    default: ;
                endcase
            end
            if (rx_if.valid && rx_if.ready) begin
                deframe_predict(rx_if.rx_byte);
                rx_taken <= rx_taken + 1;
            end
        end
    end

    // watchdog on cycles with no handshake at all
    always @(posedge i_clk) begin
        if ((rx_if.valid && rx_if.ready) || (frame_if.valid && frame_if.ready) ||
            (cfg_if.valid && cfg_if.ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, stall_cycles);
            $display("== FAIL ==");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // stimulus sequence
    initial begin
        t_byte v;
        i_rst_n       = 1'b0;
        rx_if.valid   = 1'b0;
        rx_if.rx_byte = '0;
        frame_if.ready = 1'b0;
        cfg_if.valid  = 1'b0;
        cfg_if.index  = CFG_SYNC_FIRST;
        cfg_if.data   = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset sync pair, hunting noise, broken pairs, short frames
        sink_mode   = IDLE_RANDOM;
        source_gaps = 1'b1;
        queue_byte(8'h00);
        queue_byte(8'hFF);
        queue_byte(cur_first);
        queue_byte(8'h00);
        queue_byte(cur_first);
        queue_byte(cur_first);
        queue_byte(cur_second);
        push_frame(0, 2);
        push_frame(1, 2);
        push_frame(2, 3);
        // left waiting for the second sync byte across a register write
        queue_byte(cur_first);
        settle();

        // second sync byte changed mid-pair, then the longest frame
        write_reg(CFG_SYNC_SECOND, SYNC_FIRST_ALT);
        sink_mode   = IDLE_NONE;
        source_gaps = 1'b0;
        queue_byte(cur_second);
        queue_byte(8'hFF);
        repeat (256) queue_byte(rand_byte());
        settle();

        // alternative first sync byte; unused indexes ignored
        write_reg(CFG_SYNC_FIRST, SYNC_FIRST_ALT);
        write_reg(CFG_SYNC_SECOND, SYNC_SECOND_RST);
        write_reg(CFG_SPARE_LO, 8'hFF);
        write_reg(CFG_SPARE_HI, 8'h00);
        sink_mode   = IDLE_RANDOM;
        source_gaps = 1'b1;
        push_traffic(80);
        settle();

        write_reg(CFG_SYNC_FIRST, 8'h00);
        write_reg(CFG_SYNC_SECOND, 8'hFF);
        sink_mode = IDLE_PERIODIC;
        push_traffic(80);
        settle();

        // long receiver hold-off falls in this stretch
        write_reg(CFG_SYNC_FIRST, 8'hFF);
        write_reg(CFG_SYNC_SECOND, 8'h00);
        sink_mode = IDLE_RANDOM;
        push_traffic(100);
        settle();

        // both sync bytes equal
        v = rand_byte();
        write_reg(CFG_SYNC_FIRST, v);
        write_reg(CFG_SYNC_SECOND, v);
        sink_mode = IDLE_NONE;
        push_traffic(50);
        settle();

        write_reg(CFG_SYNC_FIRST, rand_byte());
        write_reg(CFG_SYNC_SECOND, rand_byte());
        sink_mode   = IDLE_PERIODIC;
        source_gaps = 1'b0;
        push_traffic(60);
        settle();

        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
